// ===== rtl/rbot_pkg.sv =====
// Shared types and constants for the receive buffer ownership tracker.
// Used by rbot_decide and rx_buffer_ownership_tracker_top; no dependencies.
package rbot_pkg;

    localparam int BUF_TOTAL   = 16;
    localparam int IDX_W       = $clog2(BUF_TOTAL);
    localparam int CNT_W       = $clog2(BUF_TOTAL + 1);
    localparam int IMM_W       = 32;
    localparam int IMM_IDX_W   = 16;
    localparam int META_W      = 16;
    localparam int CODE_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    // actions
    localparam logic [1:0] ACT_COMPLETION = 2'd0;
    localparam logic [1:0] ACT_TAKE       = 2'd1;
    localparam logic [1:0] ACT_RETURN     = 2'd2;

    // completion kinds
    localparam logic [1:0] KIND_RECV_IMM  = 2'd0;
    localparam logic [1:0] KIND_SEND_DONE = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFERS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_UP        = 2'd1;

    // result codes
    localparam logic [CODE_W-1:0] RC_OK               = 3'd0;
    localparam logic [CODE_W-1:0] RC_NOT_CONNECTED    = 3'd1;
    localparam logic [CODE_W-1:0] RC_COMPLETION_ERROR = 3'd2;
    localparam logic [CODE_W-1:0] RC_BAD_OPCODE       = 3'd3;
    localparam logic [CODE_W-1:0] RC_BAD_STATE        = 3'd4;
    localparam logic [CODE_W-1:0] RC_NO_SUCH_BUFFER   = 3'd5;
    localparam logic [CODE_W-1:0] RC_NONE_READY       = 3'd6;

    localparam logic [CNT_W-1:0] RESET_BUFFERS_IN_USE = 5'd16;

    // Outcome of one item: result fields plus the entry update it implies.
    // notify means store size and mark ready, take means ready -> in
    // consumption, done means in consumption -> free.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  index;
        logic              notify;
        logic              take;
        logic              done;
    } rbot_dec_t;

endpackage

// ===== rtl/rbot_decide.sv =====
// Item decoder: checks an item against config and buffer ownership vectors.
// Depends on rbot_pkg; picks the lowest ready buffer for a take.
module rbot_decide (
    input  logic [1:0]                          action,
    input  logic                                completion_ok,
    input  logic [1:0]                          completion_kind,
    input  logic [rbot_pkg::IMM_IDX_W-1:0]      comp_index,
    input  logic [rbot_pkg::IDX_W-1:0]          buffer_index,
    input  logic [rbot_pkg::CNT_W-1:0]          buffers_in_use,
    input  logic                                link_up,
    input  logic [rbot_pkg::BUF_TOTAL-1:0]      ready_vec,
    input  logic [rbot_pkg::BUF_TOTAL-1:0]      consume_vec,
    output rbot_pkg::rbot_dec_t                 dec
);

    logic [rbot_pkg::CNT_W-1:0]       count;
    logic [rbot_pkg::BUF_TOTAL-1:0]   active_mask;
    logic [rbot_pkg::BUF_TOTAL-1:0]   cand;
    logic                             hit;
    logic [rbot_pkg::IDX_W-1:0]       hit_idx;
    logic [rbot_pkg::IDX_W-1:0]       comp_idx;

    assign count = (buffers_in_use > rbot_pkg::CNT_W'(rbot_pkg::BUF_TOTAL))
                 ? rbot_pkg::CNT_W'(rbot_pkg::BUF_TOTAL) : buffers_in_use;
    assign comp_idx = comp_index[rbot_pkg::IDX_W-1:0];

    always_comb begin
        for (int i = 0; i < rbot_pkg::BUF_TOTAL; i++) begin
            active_mask[i] = (rbot_pkg::CNT_W'(i) < count);
        end
    end

    assign cand = ready_vec & active_mask;

    // lowest set bit wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = rbot_pkg::BUF_TOTAL - 1; i >= 0; i--) begin
            if (cand[i]) begin
                hit     = 1'b1;
                hit_idx = rbot_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        dec = '{code: rbot_pkg::RC_OK, index: '0, notify: 1'b0, take: 1'b0,
                done: 1'b0};
        unique case (action)
            rbot_pkg::ACT_COMPLETION: begin
                if (!completion_ok) begin
                    dec.code = rbot_pkg::RC_COMPLETION_ERROR;
                end else if (completion_kind == rbot_pkg::KIND_SEND_DONE) begin
                    dec.code = rbot_pkg::RC_OK;
                end else if (completion_kind != rbot_pkg::KIND_RECV_IMM) begin
                    dec.code = rbot_pkg::RC_BAD_OPCODE;
                end else if (comp_index >= rbot_pkg::IMM_IDX_W'(count)) begin
                    dec.code  = rbot_pkg::RC_NO_SUCH_BUFFER;
                    dec.index = comp_idx;
                end else if (ready_vec[comp_idx] || consume_vec[comp_idx]) begin
                    dec.code  = rbot_pkg::RC_BAD_STATE;
                    dec.index = comp_idx;
                end else begin
                    dec.index  = comp_idx;
                    dec.notify = 1'b1;
                end
            end
            rbot_pkg::ACT_TAKE: begin
                if (!link_up) begin
                    dec.code = rbot_pkg::RC_NOT_CONNECTED;
                end else if (!hit) begin
                    dec.code = rbot_pkg::RC_NONE_READY;
                end else begin
                    dec.index = hit_idx;
                    dec.take  = 1'b1;
                end
            end
            rbot_pkg::ACT_RETURN: begin
                if (!link_up) begin
                    dec.code = rbot_pkg::RC_NOT_CONNECTED;
                end else if ({1'b0, buffer_index} >= count) begin
                    dec.code  = rbot_pkg::RC_NO_SUCH_BUFFER;
                    dec.index = buffer_index;
                end else if (!consume_vec[buffer_index]) begin
                    dec.code  = rbot_pkg::RC_BAD_STATE;
                    dec.index = buffer_index;
                end else begin
                    dec.index = buffer_index;
                    dec.done  = 1'b1;
                end
            end
            default: begin
                dec.code = rbot_pkg::RC_BAD_OPCODE;
            end
        endcase
    end

endmodule

// ===== rtl/rx_buffer_ownership_tracker_top.sv =====
// Top level of the receive buffer ownership tracker.
// Depends on rbot_pkg and rbot_decide; holds the metadata memory and control.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  s_      | in        | s_valid / s_ready   | action, completion_ok/kind,
//          |           |                     | immediate, buffer_index
//  m_      | out       | m_valid / m_ready   | result_code, out_index,
//          |           |                     | out_meta_size, notify_ready, send_done
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// On the accept edge an item is decided, the ownership vectors are updated and
// the metadata memory read starts; the result then moves from the pending register
// into the output register once that is empty or draining. The memory read is registered.
// A stalled output holds the pending result; the input waits until it moves.
// Reset (synchronous, active low) frees every buffer at once; no clearing pass.
// cfg_ready is always high.
module rx_buffer_ownership_tracker_top (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_action,
    input  logic                                s_completion_ok,
    input  logic [1:0]                          s_completion_kind,
    input  logic [rbot_pkg::IMM_W-1:0]          s_immediate,
    input  logic [rbot_pkg::IDX_W-1:0]          s_buffer_index,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rbot_pkg::CODE_W-1:0]         m_result_code,
    output logic [rbot_pkg::IDX_W-1:0]          m_out_index,
    output logic [rbot_pkg::META_W-1:0]         m_out_meta_size,
    output logic                                m_notify_ready,
    output logic                                m_send_done,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rbot_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbot_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PEND = 1'b1;

    logic                             state_reg, state_next;
    logic [rbot_pkg::CNT_W-1:0]       buffers_in_use_reg;
    logic                             link_up_reg;
    logic [rbot_pkg::BUF_TOTAL-1:0]   ready_vec_reg, ready_vec_next;
    logic [rbot_pkg::BUF_TOTAL-1:0]   consume_vec_reg, consume_vec_next;

    rbot_pkg::rbot_dec_t              dec;
    rbot_pkg::rbot_dec_t              pend_reg;

    // metadata store: one write port, one registered read port
    logic [rbot_pkg::META_W-1:0]      meta_mem [rbot_pkg::BUF_TOTAL];
    logic [rbot_pkg::META_W-1:0]      rd_data_reg;

    logic                             m_valid_reg;
    logic [rbot_pkg::CODE_W-1:0]      m_code_reg;
    logic [rbot_pkg::IDX_W-1:0]       m_index_reg;
    logic [rbot_pkg::META_W-1:0]      m_meta_reg;
    logic                             m_notify_reg;
    logic                             m_done_reg;

    logic                             s_accept;
    logic                             out_load;
    logic                             cfg_accept;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    // move the pending result once the output register is empty or draining
    assign out_load   = (state_reg == ST_PEND) && (!m_valid_reg || m_ready);

    rbot_decide u_decide (
        .action          (s_action),
        .completion_ok   (s_completion_ok),
        .completion_kind (s_completion_kind),
        .comp_index      (s_immediate[rbot_pkg::IMM_W-1:rbot_pkg::IMM_W-rbot_pkg::IMM_IDX_W]),
        .buffer_index    (s_buffer_index),
        .buffers_in_use  (buffers_in_use_reg),
        .link_up         (link_up_reg),
        .ready_vec       (ready_vec_reg),
        .consume_vec     (consume_vec_reg),
        .dec             (dec)
    );

    // Sequencer: accept in IDLE, hand the result over from PEND.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) state_next = ST_PEND;
            end
            ST_PEND: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Ownership vectors: ready and in-consumption bits, free when both clear.
    always_comb begin
        ready_vec_next   = ready_vec_reg;
        consume_vec_next = consume_vec_reg;
        if (s_accept) begin
            if (dec.notify) begin
                ready_vec_next[dec.index] = 1'b1;
            end
            if (dec.take) begin
                ready_vec_next[dec.index]   = 1'b0;
                consume_vec_next[dec.index] = 1'b1;
            end
            if (dec.done) begin
                consume_vec_next[dec.index] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            ready_vec_reg      <= '0;
            consume_vec_reg    <= '0;
            buffers_in_use_reg <= rbot_pkg::RESET_BUFFERS_IN_USE;
            link_up_reg        <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg       <= state_next;
            ready_vec_reg   <= ready_vec_next;
            consume_vec_reg <= consume_vec_next;
            if (cfg_accept) begin
                unique case (cfg_index)
                    rbot_pkg::CFG_BUFFERS_IN_USE: buffers_in_use_reg <= cfg_data;
                    rbot_pkg::CFG_LINK_UP:        link_up_reg        <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Store size on a good completion; read the entry every accept, used by take.
    // Only one item is in flight; a notify reads the old entry as it writes it, but only a take uses the read.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (dec.notify) begin
                meta_mem[dec.index] <= s_immediate[rbot_pkg::META_W-1:0];
            end
            rd_data_reg <= meta_mem[dec.index];
            pend_reg    <= dec;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_code_reg   <= pend_reg.code;
            m_index_reg  <= pend_reg.index;
            m_meta_reg   <= pend_reg.take ? rd_data_reg : '0;
            m_notify_reg <= pend_reg.notify;
            m_done_reg   <= pend_reg.done;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_code   = m_code_reg;
    assign m_out_index     = m_index_reg;
    assign m_out_meta_size = m_meta_reg;
    assign m_notify_ready  = m_notify_reg;
    assign m_send_done     = m_done_reg;

`ifndef SYNTHESIS
    // A buffer is never ready and in consumption at once.
    a_owner_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (ready_vec_reg & consume_vec_reg) == '0)
        else $error("buffer both ready and in consumption");

    // An accepted item is held pending on the next cycle.
    a_accept_pends: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_PEND))
        else $error("accepted item not pending");

    // A shown result never claims both notify and send-done, and either means ok.
    a_flags_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_notify_reg || m_done_reg) |->
            !(m_notify_reg && m_done_reg) && (m_code_reg == rbot_pkg::RC_OK))
        else $error("inconsistent result flags");

    // A take that succeeded leaves its buffer in consumption.
    a_take_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && dec.take |=> consume_vec_reg[$past(dec.index)]
            && !ready_vec_reg[$past(dec.index)])
        else $error("taken buffer not in consumption");
`endif

endmodule
